/* hdl/ipft_pkg.sv */
// Shared types and constants for the IP flow tuple extractor.
// No dependencies; every other file refers to this package by scoped names.
package ipft_pkg;

  // IP version nibbles
  localparam logic [3:0] VER4 = 4'd4;
  localparam logic [3:0] VER6 = 4'd6;

  // Protocol / next header numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Protocol kind codes in the flow record
  localparam logic [1:0] KIND_TCP  = 2'd0;
  localparam logic [1:0] KIND_UDP  = 2'd1;
  localparam logic [1:0] KIND_ICMP = 2'd2;

  // Header byte offsets
  localparam logic [15:0] OFF_V4_PROTO = 16'd9;
  localparam logic [15:0] OFF_V6_NEXT  = 16'd6;
  localparam logic [5:0]  V6_PORT_BASE = 6'd40;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // One packet byte as it travels from the input register to the parser
  typedef struct packed {
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [63:0] arrival_time;
  } byte_item_t;

  // One flow record
  typedef struct packed {
    logic        record_valid;
    logic [2:0]  ip_version;
    logic [1:0]  protocol_kind;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] packet_length;
    logic [63:0] packet_time;
  } flow_record_t;

endpackage

/* hdl/ipft_in_reg.sv */
// Input register for packet bytes: holds one accepted item for the parser.
// Depends on ipft_pkg (byte_item_t).
module ipft_in_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipft_pkg::byte_item_t  in_item,
  output logic                  item_valid,
  output ipft_pkg::byte_item_t  item,
  input  logic                  item_take
);

  // accept when empty or when the held item moves on this cycle
  assign in_ready = !item_valid || item_take;

  // hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* hdl/ipft_parser.sv */
// Header parser: per-packet capture state, offset-selected byte capture and
// flow record assembly. Depends on ipft_pkg.
module ipft_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  ipft_pkg::byte_item_t    item,
  input  logic                    rec_free,
  output logic                    item_take,
  output logic                    rec_load,
  output ipft_pkg::flow_record_t  record
);

  // capture state
  logic [15:0] byte_count;
  logic [3:0]  version_nibble;
  logic [3:0]  header_words;
  logic [7:0]  proto_number;
  logic [63:0] src_hi;
  logic [63:0] src_lo;
  logic [63:0] dst_hi;
  logic [63:0] dst_lo;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [63:0] pkt_time;

  logic [15:0] byte_count_next;
  logic [3:0]  version_next;
  logic [3:0]  header_words_next;
  logic [7:0]  proto_next;
  logic [63:0] src_hi_next;
  logic [63:0] src_lo_next;
  logic [63:0] dst_hi_next;
  logic [63:0] dst_lo_next;
  logic [15:0] sport_next;
  logic [15:0] dport_next;
  logic [63:0] pkt_time_next;

  logic [15:0] off;
  logic [7:0]  b;
  logic        first;
  logic        is_v4;
  logic        is_v6;
  logic [5:0]  port_base;
  logic [15:0] port_diff;
  logic        port_hit;
  logic        valid;
  logic [1:0]  kind;

  // a last byte needs the record slot; other bytes always move on
  assign item_take = item_valid && (!item.last_byte || rec_free);
  assign rec_load  = item_take && item.last_byte;

  assign off   = byte_count;
  assign b     = item.byte_value;
  assign first = (byte_count == 16'd0);

  // first byte restarts the capture state
  always_comb begin
    version_next      = first ? b[7:4] : version_nibble;
    header_words_next = first ? b[3:0] : header_words;
    pkt_time_next     = first ? item.arrival_time : pkt_time;
  end

  assign is_v4 = (version_next == ipft_pkg::VER4);
  assign is_v6 = (version_next == ipft_pkg::VER6);

  // protocol / next header
  always_comb begin
    proto_next = first ? 8'd0 : proto_number;
    if ((is_v4 && off == ipft_pkg::OFF_V4_PROTO) || (is_v6 && off == ipft_pkg::OFF_V6_NEXT)) begin
      proto_next = b;
    end
  end

  // address byte lanes, big-endian
  always_comb begin
    src_hi_next = first ? 64'd0 : src_hi;
    src_lo_next = first ? 64'd0 : src_lo;
    dst_hi_next = first ? 64'd0 : dst_hi;
    dst_lo_next = first ? 64'd0 : dst_lo;
    for (int k = 0; k < 8; k++) begin
      if (is_v6 && off == 16'(15 - k)) begin
        src_hi_next[k*8 +: 8] = b;
      end
      if ((is_v6 && off == 16'(23 - k)) || (is_v4 && k < 4 && off == 16'(15 - k))) begin
        src_lo_next[k*8 +: 8] = b;
      end
      if (is_v6 && off == 16'(31 - k)) begin
        dst_hi_next[k*8 +: 8] = b;
      end
      if ((is_v6 && off == 16'(39 - k)) || (is_v4 && k < 4 && off == 16'(19 - k))) begin
        dst_lo_next[k*8 +: 8] = b;
      end
    end
  end

  // ports at IHL*4 for IPv4, fixed offset for IPv6
  assign port_base = is_v4 ? {header_words_next, 2'b00} : ipft_pkg::V6_PORT_BASE;
  assign port_diff = off - {10'd0, port_base};
  assign port_hit  = (is_v4 || is_v6) && (off >= {10'd0, port_base})
                     && (port_diff[15:2] == 14'd0);

  always_comb begin
    sport_next = first ? 16'd0 : sport;
    dport_next = first ? 16'd0 : dport;
    if (port_hit) begin
      case (port_diff[1:0])
        2'd0:    sport_next[15:8] = b;
        2'd1:    sport_next[7:0]  = b;
        2'd2:    dport_next[15:8] = b;
        default: dport_next[7:0]  = b;
      endcase
    end
  end

  // saturating byte counter
  assign byte_count_next = (off == ipft_pkg::COUNT_MAX) ? off : off + 16'd1;

  // classify packet
  always_comb begin
    valid = 1'b0;
    kind  = ipft_pkg::KIND_TCP;
    if (proto_next == ipft_pkg::PROTO_TCP && (is_v4 || is_v6)) begin
      valid = 1'b1;
      kind  = ipft_pkg::KIND_TCP;
    end else if (proto_next == ipft_pkg::PROTO_UDP && (is_v4 || is_v6)) begin
      valid = 1'b1;
      kind  = ipft_pkg::KIND_UDP;
    end else if (proto_next == ipft_pkg::PROTO_ICMP && is_v4) begin
      valid = 1'b1;
      kind  = ipft_pkg::KIND_ICMP;
    end
  end

  // assemble record, all zero when unsupported
  always_comb begin
    record = '0;
    if (valid) begin
      record.record_valid     = 1'b1;
      record.ip_version       = version_next[2:0];
      record.protocol_kind    = kind;
      record.source_addr_high = src_hi_next;
      record.source_addr_low  = src_lo_next;
      record.dest_addr_high   = dst_hi_next;
      record.dest_addr_low    = dst_lo_next;
      record.source_port      = (kind == ipft_pkg::KIND_ICMP) ? 16'd0 : sport_next;
      record.dest_port        = (kind == ipft_pkg::KIND_ICMP) ? 16'd0 : dport_next;
      record.packet_length    = byte_count_next;
      record.packet_time      = pkt_time_next;
    end
  end

  // advance byte counter, restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 16'd0;
    end else if (item_take) begin
      byte_count <= item.last_byte ? 16'd0 : byte_count_next;
    end
  end

  // capture fields; a zero count overrides them on the next packet
  always_ff @(posedge clk) begin
    if (item_take) begin
      version_nibble <= version_next;
      header_words   <= header_words_next;
      proto_number   <= proto_next;
      src_hi         <= src_hi_next;
      src_lo         <= src_lo_next;
      dst_hi         <= dst_hi_next;
      dst_lo         <= dst_lo_next;
      sport          <= sport_next;
      dport          <= dport_next;
      pkt_time       <= pkt_time_next;
    end
  end

endmodule

/* hdl/ipft_out_reg.sv */
// Output register for flow records with valid/ready handshake.
// Depends on ipft_pkg (flow_record_t).
module ipft_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rec_load,
  input  ipft_pkg::flow_record_t  rec_in,
  output logic                    rec_free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ipft_pkg::flow_record_t  rec_out
);

  // slot frees when empty or drained this cycle
  assign rec_free = !out_valid || out_ready;

  // hold valid until the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load payload
  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_out <= rec_in;
    end
  end

endmodule

/* hdl/ip_flow_tuple_extractor.sv */
// IP flow tuple extractor: one packet byte per cycle in, one flow record per packet out.
// The last byte passes the input register; its record then loads the output register and raises out_valid.
// Throughput: 1 byte per cycle; a last byte waits only while the previous record is unread.
// Reset clears the byte counter and both valid flags; capture registers reload on first byte.
// Uses ipft_pkg, ipft_in_reg, ipft_parser and ipft_out_reg.
module ip_flow_tuple_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic [63:0] arrival_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        record_valid,
  output logic [2:0]  ip_version,
  output logic [1:0]  protocol_kind,
  output logic [63:0] source_addr_high,
  output logic [63:0] source_addr_low,
  output logic [63:0] dest_addr_high,
  output logic [63:0] dest_addr_low,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [15:0] packet_length,
  output logic [63:0] packet_time
);

  ipft_pkg::byte_item_t   in_item;
  ipft_pkg::byte_item_t   item;
  ipft_pkg::flow_record_t record;
  ipft_pkg::flow_record_t rec_out;
  logic                   item_valid;
  logic                   item_take;
  logic                   rec_load;
  logic                   rec_free;

  // pack input fields
  always_comb begin
    in_item.byte_value   = byte_value;
    in_item.last_byte    = last_byte;
    in_item.arrival_time = arrival_time;
  end

  ipft_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ipft_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .rec_free   (rec_free),
    .item_take  (item_take),
    .rec_load   (rec_load),
    .record     (record)
  );

  ipft_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .rec_load  (rec_load),
    .rec_in    (record),
    .rec_free  (rec_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rec_out   (rec_out)
  );

  // unpack record fields
  assign record_valid     = rec_out.record_valid;
  assign ip_version       = rec_out.ip_version;
  assign protocol_kind    = rec_out.protocol_kind;
  assign source_addr_high = rec_out.source_addr_high;
  assign source_addr_low  = rec_out.source_addr_low;
  assign dest_addr_high   = rec_out.dest_addr_high;
  assign dest_addr_low    = rec_out.dest_addr_low;
  assign source_port      = rec_out.source_port;
  assign dest_port        = rec_out.dest_port;
  assign packet_length    = rec_out.packet_length;
  assign packet_time      = rec_out.packet_time;

endmodule

/* hdl/ipft_checker.sv */
// Port-level checks for the IP flow tuple extractor, bound to its top level.
// Depends on ipft_pkg and ip_flow_tuple_extractor.
module ipft_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        record_valid,
  input logic [2:0]  ip_version,
  input logic [1:0]  protocol_kind,
  input logic [63:0] source_addr_high,
  input logic [63:0] source_addr_low,
  input logic [63:0] dest_addr_high,
  input logic [63:0] dest_addr_low,
  input logic [15:0] source_port,
  input logic [15:0] dest_port,
  input logic [15:0] packet_length,
  input logic [63:0] packet_time
);

  // stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(record_valid) && $stable(source_addr_low)
      && $stable(dest_addr_low) && $stable(packet_length) && $stable(packet_time))
    else $error("stalled record changed");

  // unsupported packet gives an all-zero record
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !record_valid |-> ip_version == 3'd0 && protocol_kind == 2'd0
      && source_addr_high == 64'd0 && source_addr_low == 64'd0
      && dest_addr_high == 64'd0 && dest_addr_low == 64'd0 && source_port == 16'd0
      && dest_port == 16'd0 && packet_length == 16'd0 && packet_time == 64'd0)
    else $error("invalid record carries data");

  // valid record has a supported version and a nonzero length
  a_valid_version: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_valid |-> (ip_version == 3'd4 || ip_version == 3'd6)
      && packet_length != 16'd0)
    else $error("valid record with bad version or length");

  // ICMP only on IPv4, without ports
  a_icmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_valid && protocol_kind == ipft_pkg::KIND_ICMP |->
      ip_version == 3'd4 && source_port == 16'd0 && dest_port == 16'd0)
    else $error("bad ICMP record");

  // IPv4 addresses use the low 32 bits only
  a_v4_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_valid && ip_version == 3'd4 |->
      source_addr_high == 64'd0 && dest_addr_high == 64'd0
      && source_addr_low[63:32] == 32'd0 && dest_addr_low[63:32] == 32'd0)
    else $error("IPv4 address beyond 32 bits");

endmodule

bind ip_flow_tuple_extractor ipft_checker u_ipft_checker (.*);

/* sim/ipft_flow_checker.sv */
// Flow record checker: watches both channels of the extractor and predicts each record.
// Depends on ipft_pkg for the record type, version, protocol and offset constants.
// Hands a mismatch count and the number of records still due back to the testbench.
module ipft_flow_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic [63:0] arrival_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        record_valid,
  input  logic [2:0]  ip_version,
  input  logic [1:0]  protocol_kind,
  input  logic [63:0] source_addr_high,
  input  logic [63:0] source_addr_low,
  input  logic [63:0] dest_addr_high,
  input  logic [63:0] dest_addr_low,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [15:0] packet_length,
  input  logic [63:0] packet_time,
  output int          mismatches,
  output int          records_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the parser state for the packet in flight
  logic [15:0]  pos_count;
  logic [3:0]   ver_nib;
  logic [3:0]   ihl_nib;
  logic [7:0]   proto_num;
  logic [127:0] saddr;
  logic [127:0] daddr;
  logic [31:0]  port_pair;
  logic [63:0]  first_time;

  ipft_pkg::flow_record_t flow_records_due [$];
  ipft_pkg::flow_record_t want_rec;
  int                     rec_index;

  task automatic clear_state();
    pos_count  = '0;
    ver_nib    = '0;
    ihl_nib    = '0;
    proto_num  = '0;
    saddr      = '0;
    daddr      = '0;
    port_pair  = '0;
    first_time = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at record %0d, %s: got %h, want %h", rec_index, what, got, want);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Advance the shadow parser by one byte; queue a record on the last byte
  task automatic take_byte(input logic [7:0] b, input logic fin, input logic [63:0] stamp);
    int                     off;
    int                     base;
    bit                     has_ports;
    ipft_pkg::flow_record_t rec;
    off       = int'(pos_count);
    base      = 0;
    has_ports = 1'b0;

    // first byte: restart capture and sample version, IHL and time
    if (off == 0) begin
      clear_state();
      ver_nib    = b[7:4];
      ihl_nib    = b[3:0];
      first_time = stamp;
    end

    if (ver_nib == ipft_pkg::VER4) begin
      if (off == int'(ipft_pkg::OFF_V4_PROTO)) proto_num = b;
      if (off >= 12 && off <= 15) saddr[(15 - off) * 8 +: 8] = b;
      if (off >= 16 && off <= 19) daddr[(19 - off) * 8 +: 8] = b;
      base      = int'(ihl_nib) * 4;
      has_ports = 1'b1;
    end else if (ver_nib == ipft_pkg::VER6) begin
      if (off == int'(ipft_pkg::OFF_V6_NEXT)) proto_num = b;
      if (off >= 8 && off <= 23) saddr[(23 - off) * 8 +: 8] = b;
      if (off >= 24 && off <= 39) daddr[(39 - off) * 8 +: 8] = b;
      base      = int'(ipft_pkg::V6_PORT_BASE);
      has_ports = 1'b1;
    end

    // ports sit in four bytes from the base, big-endian
    if (has_ports && off >= base && off < base + 4) port_pair[(base + 3 - off) * 8 +: 8] = b;

    if (pos_count != ipft_pkg::COUNT_MAX) pos_count = pos_count + 16'd1;

    if (fin) begin
      rec = '0;
      if (ver_nib == ipft_pkg::VER4 || ver_nib == ipft_pkg::VER6) begin
        if (proto_num == ipft_pkg::PROTO_TCP) begin
          rec.record_valid  = 1'b1;
          rec.protocol_kind = ipft_pkg::KIND_TCP;
        end else if (proto_num == ipft_pkg::PROTO_UDP) begin
          rec.record_valid  = 1'b1;
          rec.protocol_kind = ipft_pkg::KIND_UDP;
        end else if (proto_num == ipft_pkg::PROTO_ICMP && ver_nib == ipft_pkg::VER4) begin
          rec.record_valid  = 1'b1;
          rec.protocol_kind = ipft_pkg::KIND_ICMP;
        end
      end
      // invalid packets leave every field zero
      if (rec.record_valid) begin
        rec.ip_version       = ver_nib[2:0];
        rec.source_addr_high = saddr[127:64];
        rec.source_addr_low  = saddr[63:0];
        rec.dest_addr_high   = daddr[127:64];
        rec.dest_addr_low    = daddr[63:0];
        if (rec.protocol_kind != ipft_pkg::KIND_ICMP) begin
          rec.source_port = port_pair[31:16];
          rec.dest_port   = port_pair[15:0];
        end
        rec.packet_length = pos_count;
        rec.packet_time   = first_time;
      end
      flow_records_due.push_back(rec);
      clear_state();
    end
  endtask

  // Predict on accepted bytes, compare on accepted records
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      flow_records_due.delete();
    end else begin
      if (in_valid && in_ready) take_byte(byte_value, last_byte, arrival_time);
      if (out_valid && out_ready) begin
        if (flow_records_due.size() == 0) begin
          report_mismatch("record with nothing due", 64'd1, 64'd0);
        end else begin
          want_rec = flow_records_due.pop_front();
          check_field("record_valid", 64'(record_valid), 64'(want_rec.record_valid));
          check_field("ip_version", 64'(ip_version), 64'(want_rec.ip_version));
          check_field("protocol_kind", 64'(protocol_kind), 64'(want_rec.protocol_kind));
          check_field("source_addr_high", source_addr_high, want_rec.source_addr_high);
          check_field("source_addr_low", source_addr_low, want_rec.source_addr_low);
          check_field("dest_addr_high", dest_addr_high, want_rec.dest_addr_high);
          check_field("dest_addr_low", dest_addr_low, want_rec.dest_addr_low);
          check_field("source_port", 64'(source_port), 64'(want_rec.source_port));
          check_field("dest_port", 64'(dest_port), 64'(want_rec.dest_port));
          check_field("packet_length", 64'(packet_length), 64'(want_rec.packet_length));
          check_field("packet_time", packet_time, want_rec.packet_time);
        end
        rec_index = rec_index + 1;
      end
    end
    records_due <= flow_records_due.size();
  end

endmodule

/* sim/tb_ip_flow_tuple_extractor.sv */
// Testbench top for the IP flow tuple extractor: clock, reset, packet stimulus and verdict.
// Depends on ipft_pkg, the extractor RTL and ipft_flow_checker, which does the record checking.
module tb_ip_flow_tuple_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLD_CYCLES    = 250;
  localparam int RANDOM_BYTES   = 140;
  localparam int RANDOM_RECORDS = 18;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic [63:0] arrival_time;
  logic        out_valid;
  logic        out_ready;
  logic        record_valid;
  logic [2:0]  ip_version;
  logic [1:0]  protocol_kind;
  logic [63:0] source_addr_high;
  logic [63:0] source_addr_low;
  logic [63:0] dest_addr_high;
  logic [63:0] dest_addr_low;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] packet_length;
  logic [63:0] packet_time;
  int          mismatches;
  int          records_due;

  logic [7:0] pkt_bytes [$];
  bit         no_idle;
  bit         hold_req;
  bit         holding;
  int         idle_cycles;
  int         bytes_sent;
  int         packets_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ip_flow_tuple_extractor uut (.*);

  ipft_flow_checker chk (.*);

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte and hold it until accepted, then maybe idle
  task automatic push_byte(input logic [7:0] b, input logic fin, input logic [63:0] stamp);
    int gap;
    in_valid     <= 1'b1;
    byte_value   <= b;
    last_byte    <= fin;
    arrival_time <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Fill the packet with random bytes, then set version/IHL and protocol
  task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input int len);
    pkt_bytes.delete();
    for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
    pkt_bytes[0] = {ver, ihl};
    if (ver == ipft_pkg::VER6) begin
      if (len > int'(ipft_pkg::OFF_V6_NEXT)) pkt_bytes[ipft_pkg::OFF_V6_NEXT] = proto;
    end else if (len > int'(ipft_pkg::OFF_V4_PROTO)) begin
      pkt_bytes[ipft_pkg::OFF_V4_PROTO] = proto;
    end
  endtask

  // Send the built packet; only the first byte's time should matter
  task automatic send_packet(input logic [63:0] stamp);
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, i == 0 ? stamp : {$urandom, $urandom});
    end
    bytes_sent   += pkt_bytes.size();
    packets_sent += 1;
  endtask

  // Stop offering and wait until every predicted record has come out
  task automatic drain_records();
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
  endtask

  // Mostly well-formed TCP/UDP/ICMP packets, some truncated, the rest noise
  task automatic random_packet();
    int         r;
    int         ihl;
    int         len;
    logic [7:0] proto;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 15);
      case ($urandom_range(0, 2))
        0: proto = ipft_pkg::PROTO_TCP;
        1: proto = ipft_pkg::PROTO_UDP;
        default: proto = ipft_pkg::PROTO_ICMP;
      endcase
      len = ((ihl * 4 + 4 > 20) ? ihl * 4 + 4 : 20) + $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
      build_packet(ipft_pkg::VER4, 4'(ihl), proto, len);
    end else if (r < 80) begin
      proto = $urandom_range(0, 1) ? ipft_pkg::PROTO_TCP : ipft_pkg::PROTO_UDP;
      len   = 44 + $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
      build_packet(ipft_pkg::VER6, 4'($urandom), proto, len);
    end else begin
      proto = $urandom_range(0, 2) == 0 ? ipft_pkg::PROTO_ICMP : 8'($urandom);
      build_packet(4'($urandom), 4'($urandom), proto, $urandom_range(1, 70));
    end
    send_packet({$urandom, $urandom});
  endtask

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    int busy;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holding  = 1'b0;
      end else begin
        busy = no_idle ? 0 : pick_gap();
        if (busy == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (busy) @(posedge clk);
        end
      end
    end
  end

  // Count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus
  initial begin
    in_valid     <= 1'b0;
    byte_value   <= '0;
    last_byte    <= 1'b0;
    arrival_time <= '0;
    rst          <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // basic v4 and v6 flows, timestamp extremes
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_TCP, 40);
    send_packet('0);
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_UDP, 28);
    send_packet('1);
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_ICMP, 36);
    send_packet({$urandom, $urandom});
    build_packet(ipft_pkg::VER6, 4'd0, ipft_pkg::PROTO_TCP, 60);
    send_packet({$urandom, $urandom});
    build_packet(ipft_pkg::VER6, 4'd15, ipft_pkg::PROTO_UDP, 44);
    send_packet({$urandom, $urandom});
    // ICMP is not accepted on v6
    build_packet(ipft_pkg::VER6, 4'd3, ipft_pkg::PROTO_ICMP, 50);
    send_packet({$urandom, $urandom});
    // IHL at the top, at zero and overlapping the fixed header
    build_packet(ipft_pkg::VER4, 4'd15, ipft_pkg::PROTO_TCP, 64);
    send_packet({$urandom, $urandom});
    build_packet(ipft_pkg::VER4, 4'd0, ipft_pkg::PROTO_UDP, 24);
    send_packet({$urandom, $urandom});
    build_packet(ipft_pkg::VER4, 4'd2, ipft_pkg::PROTO_TCP, 30);
    send_packet({$urandom, $urandom});
    // unsupported protocol and versions
    build_packet(ipft_pkg::VER4, 4'd5, 8'hFF, 40);
    send_packet({$urandom, $urandom});
    build_packet(4'h0, 4'd5, ipft_pkg::PROTO_TCP, 40);
    send_packet({$urandom, $urandom});
    build_packet(4'hF, 4'd5, ipft_pkg::PROTO_UDP, 40);
    send_packet({$urandom, $urandom});
    build_packet(4'h5, 4'd5, ipft_pkg::PROTO_TCP, 40);
    send_packet({$urandom, $urandom});
    // short packets: missing bytes read as zero
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_TCP, 10);
    send_packet({$urandom, $urandom});
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_TCP, 1);
    send_packet({$urandom, $urandom});
    build_packet(ipft_pkg::VER6, 4'd0, ipft_pkg::PROTO_UDP, 20);
    send_packet({$urandom, $urandom});
    // all-ones and all-zeros payloads
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_TCP, 40);
    foreach (pkt_bytes[i]) if (i != 0 && i != int'(ipft_pkg::OFF_V4_PROTO)) pkt_bytes[i] = 8'hFF;
    send_packet('1);
    build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_UDP, 40);
    foreach (pkt_bytes[i]) if (i != 0 && i != int'(ipft_pkg::OFF_V4_PROTO)) pkt_bytes[i] = 8'h00;
    send_packet('0);
    build_packet(4'hF, 4'hF, 8'hFF, 30);
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'hFF;
    send_packet({$urandom, $urandom});

    // random traffic
    bytes_sent   = 0;
    packets_sent = 0;
    while (bytes_sent < RANDOM_BYTES || packets_sent < RANDOM_RECORDS) begin
      if (packets_sent == 2) begin
        // hold the receiver off and offer fourteen small packets so that input stalls
        hold_req = 1'b1;
        wait (holding);
        repeat (14) begin
          build_packet(ipft_pkg::VER4, 4'd5, ipft_pkg::PROTO_UDP, $urandom_range(1, 4));
          send_packet({$urandom, $urandom});
        end
        drain_records();
      end
      if ($urandom_range(0, 19) == 0) drain_records();
      no_idle = (packets_sent >= 16 && packets_sent < 18);
      random_packet();
    end
    no_idle = 1'b0;

    drain_records();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ipft_pkg.sv
hdl/ipft_in_reg.sv
hdl/ipft_parser.sv
hdl/ipft_out_reg.sv
hdl/ip_flow_tuple_extractor.sv
hdl/ipft_checker.sv
sim/ipft_flow_checker.sv
sim/tb_ip_flow_tuple_extractor.sv
